FILE: rtl/rcr3_pkg.sv
`timescale 1ns / 1ps

package rcr3_pkg;

    localparam int PIX_W     = 16;
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 12;
    localparam int ROW_W     = 16;
    localparam int RANK_W    = 3;
    localparam int RK_W      = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int IN_W   = 32;
    localparam int OX_W   = 11;
    localparam int OY_W   = 16;
    localparam int OV_W   = 16;
    localparam int OX_LSB = 0;
    localparam int OY_LSB = OX_LSB + OX_W;
    localparam int OV_LSB = OY_LSB + OY_W;
    localparam int OUT_USED = OV_LSB + OV_W;
    localparam int OUT_W  = ((OUT_USED + 7) / 8) * 8;

    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [WID_W-1:0]  WIDTH_RESET  = WID_W'(1920);
    localparam logic [ROW_W-1:0]  HEIGHT_RESET = ROW_W'(1080);
    localparam logic [RANK_W-1:0] RANK_RESET   = RANK_W'(1);
    localparam logic [WID_W-1:0]  WIDTH_MIN    = WID_W'(3);
    localparam logic [WID_W-1:0]  WIDTH_MAX    = WID_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0]  HEIGHT_MIN   = ROW_W'(3);
    localparam logic [RANK_W-1:0] RANK_MAX     = RANK_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RANK   = 2'd2
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [7:0][PIX_W-1:0] t_nb;

    // mask bit 0: centre behind, bit 1: right column, bit 2: last row
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_pix             v0;
        t_pix             v1;
        t_pix             sp;
        logic [2:0]       mask;
        logic             eof;
    } t_item;

endpackage

FILE: rtl/rank_clamp_repair_3x3.sv
`timescale 1ns / 1ps

// Channel    Dir  Request                         Fields (low bit first)
// s_axis     in   one pixel pair                  src_pixel, level_pixel
// m_axis     out  one repaired pixel              out_x, out_y, value, pad; tlast=frame_end
// i_cfg      in   register write, no wait         index 0 width, 1 height, 2 rank
//
// One pixel pair per cycle while each pair yields at most one result and the output is
// not stalled; row ends and the last row can yield two or three, set by the single output port.
// Stages: line buffer read, window shift, sort half one, sort half two + clamp.
// Reset is synchronous; line buffers are not cleared, and ready is held low during reset.
// A stalled output stops input once eight pairs sit in the pipeline or the result queue.

module rank_clamp_repair_3x3 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rcr3_pkg::IN_W-1:0]    s_axis_tdata,  // src_pixel, level_pixel
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rcr3_pkg::OUT_W-1:0]   m_axis_tdata,  // out_x, out_y, value, zeros
    output logic                         m_axis_tlast,  // frame_end
    input  logic                         i_cfg_wr_en,
    input  logic [rcr3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcr3_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int PIX_W  = rcr3_pkg::PIX_W;
    localparam int COL_W  = rcr3_pkg::COL_W;
    localparam int WID_W  = rcr3_pkg::WID_W;
    localparam int ROW_W  = rcr3_pkg::ROW_W;
    localparam int RANK_W = rcr3_pkg::RANK_W;
    localparam int RK_W   = rcr3_pkg::RK_W;
    localparam int QPTR_W = rcr3_pkg::QPTR_W;

    function automatic rcr3_pkg::t_nb cs(input rcr3_pkg::t_nb v, input logic [2:0] p,
                                         input logic [2:0] q);
        rcr3_pkg::t_nb o;
        o = v;
        if (v[p] > v[q]) begin
            o[p] = v[q];
            o[q] = v[p];
        end
        return o;
    endfunction

    // configuration
    logic [WID_W-1:0]  r_width;
    logic [ROW_W-1:0]  r_height;
    logic [RANK_W-1:0] r_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rcr3_pkg::WIDTH_RESET;
            r_height <= rcr3_pkg::HEIGHT_RESET;
            r_rank   <= rcr3_pkg::RANK_RESET;
        end else if (i_cfg_wr_en) begin
            case (rcr3_pkg::t_cfg_reg'(i_cfg_index))
                rcr3_pkg::REG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                rcr3_pkg::REG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                rcr3_pkg::REG_RANK:   r_rank   <= i_cfg_data[RANK_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [QPTR_W:0]  r_items, n_items;
    logic             acc;
    rcr3_pkg::t_pix   a_sp, a_lp;
    logic [WID_W-1:0] w_eff, w_last, col_inc, col_ext;
    logic [ROW_W-1:0] h_eff;
    logic [RK_W-1:0]  a_rk;
    logic [2:0]       a_mask;
    logic             a_bord, a_eof, wrap;
    logic [ROW_W:0]   row_inc;

    assign s_axis_tready = i_rst_n && (r_items < (QPTR_W+1)'(rcr3_pkg::QDEPTH));
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign a_sp = s_axis_tdata[PIX_W-1:0];
    assign a_lp = s_axis_tdata[2*PIX_W-1:PIX_W];

    always_comb begin
        if (r_width < rcr3_pkg::WIDTH_MIN) begin
            w_eff = rcr3_pkg::WIDTH_MIN;
        end else if (r_width > rcr3_pkg::WIDTH_MAX) begin
            w_eff = rcr3_pkg::WIDTH_MAX;
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height < rcr3_pkg::HEIGHT_MIN) ? rcr3_pkg::HEIGHT_MIN : r_height;
        if (r_rank == '0) begin
            a_rk = '0;
        end else if (r_rank > rcr3_pkg::RANK_MAX) begin
            a_rk = '1;
        end else begin
            a_rk = RK_W'(r_rank - RANK_W'(1));
        end

        col_ext   = WID_W'(r_col);
        w_last    = w_eff - WID_W'(1);
        a_eof     = (col_ext == w_last);
        a_mask[0] = (r_col != '0) && (r_row != '0);
        a_mask[1] = a_eof && (r_row != '0);
        a_mask[2] = (r_row == h_eff - ROW_W'(1));
        a_bord    = (r_col == COL_W'(1)) || (col_ext >= w_eff)
                 || (r_row == ROW_W'(1)) || (r_row >= h_eff);

        col_inc = col_ext + WID_W'(1);
        wrap    = (col_inc >= w_eff);
        n_col   = wrap ? '0 : col_inc[COL_W-1:0];
        row_inc = {1'b0, r_row} + (ROW_W+1)'(wrap);
        n_row   = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line buffers: two banks of original rows by row parity, one of leveled
    rcr3_pkg::t_pix r_src0 [rcr3_pkg::MAX_WIDTH];
    rcr3_pkg::t_pix r_src1 [rcr3_pkg::MAX_WIDTH];
    rcr3_pkg::t_pix r_lvlm [rcr3_pkg::MAX_WIDTH];
    rcr3_pkg::t_pix r_q0, r_q1, r_lq;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q0 <= r_src0[r_col];
            if (!r_row[0]) begin
                r_src0[r_col] <= a_sp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q1 <= r_src1[r_col];
            if (r_row[0]) begin
                r_src1[r_col] <= a_sp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_lq <= r_lvlm[r_col];
            r_lvlm[r_col] <= a_lp;
        end
    end

    // stage B: buffer data ready, window shift
    logic             r_b_valid;
    logic [COL_W-1:0] r_b_col;
    logic [ROW_W-1:0] r_b_row;
    rcr3_pkg::t_pix   r_b_sp;
    logic [2:0]       r_b_mask;
    logic             r_b_bord, r_b_eof;
    logic [RK_W-1:0]  r_b_rk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= acc;
        end
        if (acc) begin
            r_b_col  <= r_col;
            r_b_row  <= r_row;
            r_b_sp   <= a_sp;
            r_b_mask <= a_mask;
            r_b_bord <= a_bord;
            r_b_eof  <= a_eof;
            r_b_rk   <= a_rk;
        end
    end

    rcr3_pkg::t_pix b_above2, b_above1;
    assign b_above2 = r_b_row[0] ? r_q1 : r_q0;
    assign b_above1 = r_b_row[0] ? r_q0 : r_q1;

    rcr3_pkg::t_pix   r_win [9];
    rcr3_pkg::t_pix   r_lvl_hold;
    logic             r_c_valid;
    logic [COL_W-1:0] r_c_col;
    logic [ROW_W-1:0] r_c_row;
    rcr3_pkg::t_pix   r_c_sp, r_c_v1, r_c_lvl;
    logic [2:0]       r_c_mask;
    logic             r_c_bord, r_c_eof;
    logic [RK_W-1:0]  r_c_rk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
            r_lvl_hold <= '0;
            r_c_valid  <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
            if (r_b_valid) begin
                r_win[0]   <= r_win[1];
                r_win[1]   <= r_win[2];
                r_win[2]   <= b_above2;
                r_win[3]   <= r_win[4];
                r_win[4]   <= r_win[5];
                r_win[5]   <= b_above1;
                r_win[6]   <= r_win[7];
                r_win[7]   <= r_win[8];
                r_win[8]   <= r_b_sp;
                r_lvl_hold <= r_lq;
            end
        end
        if (r_b_valid) begin
            r_c_col  <= r_b_col;
            r_c_row  <= r_b_row;
            r_c_sp   <= r_b_sp;
            r_c_v1   <= b_above1;
            r_c_lvl  <= r_lvl_hold;
            r_c_mask <= r_b_mask;
            r_c_bord <= r_b_bord;
            r_c_eof  <= r_b_eof;
            r_c_rk   <= r_b_rk;
        end
    end

    // stage C: first three layers of the sort
    rcr3_pkg::t_nb c_nb, c_l1, c_l2, c_l3;

    always_comb begin
        c_nb = {r_win[8], r_win[7], r_win[6], r_win[5],
                r_win[3], r_win[2], r_win[1], r_win[0]};
        c_l1 = cs(cs(cs(cs(c_nb, 3'd0, 3'd1), 3'd2, 3'd3), 3'd4, 3'd5), 3'd6, 3'd7);
        c_l2 = cs(cs(cs(cs(c_l1, 3'd0, 3'd2), 3'd1, 3'd3), 3'd4, 3'd6), 3'd5, 3'd7);
        c_l3 = cs(cs(c_l2, 3'd1, 3'd2), 3'd5, 3'd6);
    end

    logic             r_d_valid;
    rcr3_pkg::t_nb    r_d_nb;
    rcr3_pkg::t_pix   r_d_ctr, r_d_sp, r_d_v1, r_d_lvl;
    logic [COL_W-1:0] r_d_col;
    logic [ROW_W-1:0] r_d_row;
    logic [2:0]       r_d_mask;
    logic             r_d_bord, r_d_eof;
    logic [RK_W-1:0]  r_d_rk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        if (r_c_valid) begin
            r_d_nb   <= c_l3;
            r_d_ctr  <= r_win[4];
            r_d_sp   <= r_c_sp;
            r_d_v1   <= r_c_v1;
            r_d_lvl  <= r_c_lvl;
            r_d_col  <= r_c_col;
            r_d_row  <= r_c_row;
            r_d_mask <= r_c_mask;
            r_d_bord <= r_c_bord;
            r_d_eof  <= r_c_eof;
            r_d_rk   <= r_c_rk;
        end
    end

    // stage D: rest of the sort, rank pick, clamp
    rcr3_pkg::t_nb  d_l4, d_l5, d_srt;
    rcr3_pkg::t_pix d_lo_n, d_hi_n, d_lo, d_hi, d_fix, d_v0;
    rcr3_pkg::t_item d_item;
    logic           push, drop;

    always_comb begin
        d_l4   = cs(cs(cs(cs(r_d_nb, 3'd0, 3'd4), 3'd1, 3'd5), 3'd2, 3'd6), 3'd3, 3'd7);
        d_l5   = cs(cs(d_l4, 3'd2, 3'd4), 3'd3, 3'd5);
        d_srt  = cs(cs(cs(d_l5, 3'd1, 3'd2), 3'd3, 3'd4), 3'd5, 3'd6);
        d_lo_n = d_srt[{1'b0, r_d_rk}];
        d_hi_n = d_srt[{1'b1, ~r_d_rk}];
        d_lo   = (d_lo_n < r_d_ctr) ? d_lo_n : r_d_ctr;
        d_hi   = (d_hi_n > r_d_ctr) ? d_hi_n : r_d_ctr;
        if (r_d_lvl < d_lo) begin
            d_fix = d_lo;
        end else if (r_d_lvl > d_hi) begin
            d_fix = d_hi;
        end else begin
            d_fix = r_d_lvl;
        end
        d_v0 = r_d_bord ? r_d_ctr : d_fix;

        d_item.col  = r_d_col;
        d_item.row  = r_d_row;
        d_item.v0   = d_v0;
        d_item.v1   = r_d_v1;
        d_item.sp   = r_d_sp;
        d_item.mask = r_d_mask;
        d_item.eof  = r_d_eof;
    end

    assign push = r_d_valid && (r_d_mask != '0);
    assign drop = r_d_valid && (r_d_mask == '0);

    // result queue, one entry per pair that yields a result, drained one result at a time
    localparam int OX_W_L = rcr3_pkg::OX_W;

    rcr3_pkg::t_item r_q [rcr3_pkg::QDEPTH];
    logic [QPTR_W:0] r_wr_ptr, r_rd_ptr;
    logic [2:0]      r_done;
    rcr3_pkg::t_item head;
    logic [2:0]      pend, pick, rest;
    logic            pop, retire;
    logic [OX_W_L-1:0] o_x;
    logic [ROW_W-1:0]  o_y;
    rcr3_pkg::t_pix    o_v;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr[QPTR_W-1:0]] <= d_item;
        end
    end

    always_comb begin
        head    = r_q[r_rd_ptr[QPTR_W-1:0]];
        pend    = head.mask & ~r_done;
        pick[0] = pend[0];
        pick[1] = pend[1] & ~pend[0];
        pick[2] = pend[2] & ~(|pend[1:0]);
        rest    = pend & ~pick;
        m_axis_tvalid = (r_wr_ptr != r_rd_ptr);
        pop     = m_axis_tvalid && m_axis_tready;
        retire  = pop && (rest == '0);

        if (pick[0]) begin
            o_x          = OX_W_L'(head.col - COL_W'(1));
            o_y          = head.row - ROW_W'(1);
            o_v          = head.v0;
            m_axis_tlast = 1'b0;
        end else if (pick[1]) begin
            o_x          = OX_W_L'(head.col);
            o_y          = head.row - ROW_W'(1);
            o_v          = head.v1;
            m_axis_tlast = 1'b0;
        end else begin
            o_x          = OX_W_L'(head.col);
            o_y          = head.row;
            o_v          = head.sp;
            m_axis_tlast = head.eof;
        end
        m_axis_tdata = rcr3_pkg::OUT_W'({o_v, o_y, o_x});

        n_items = r_items + (QPTR_W+1)'(acc) - (QPTR_W+1)'(drop) - (QPTR_W+1)'(retire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_done   <= '0;
            r_items  <= '0;
        end else begin
            r_items <= n_items;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + (QPTR_W+1)'(1);
            end
            if (retire) begin
                r_rd_ptr <= r_rd_ptr + (QPTR_W+1)'(1);
                r_done   <= '0;
            end else if (pop) begin
                r_done <= r_done | pick;
            end
        end
    end

endmodule

FILE: rtl/rcr3_chk.sv
`timescale 1ns / 1ps

module rcr3_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [rcr3_pkg::IN_W-1:0]      s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rcr3_pkg::OUT_W-1:0]     m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic                           i_cfg_wr_en,
    input logic [rcr3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [rcr3_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int OXL = rcr3_pkg::OX_LSB;
    localparam int OXH = rcr3_pkg::OX_LSB + rcr3_pkg::OX_W - 1;
    localparam int OYL = rcr3_pkg::OY_LSB;
    localparam int OYH = rcr3_pkg::OY_LSB + rcr3_pkg::OY_W - 1;

    // no input taken while in reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |-> !s_axis_tready)
        else $error("input ready during reset");

    // no result is offered just after reset ends
    a_rst_latency: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !m_axis_tvalid)
        else $error("result appeared too early after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // frame end sits on the last column of the last row, never near the origin
    a_eof_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[OXH:OXL] >= rcr3_pkg::OX_W'(2)) &&
            (m_axis_tdata[OYH:OYL] >= rcr3_pkg::OY_W'(2)))
        else $error("frame end on an impossible position");

endmodule

bind rank_clamp_repair_3x3 rcr3_chk u_rcr3_chk (.*);

FILE: sim/rank_clamp_repair_3x3_checker.sv
`timescale 1ns / 1ps

module rank_clamp_repair_3x3_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [rcr3_pkg::IN_W-1:0]      i_in_data,   // src_pixel, level_pixel
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [rcr3_pkg::OUT_W-1:0]     i_out_data,  // out_x, out_y, value, zeros
    input  logic                           i_out_last,  // frame_end
    input  logic                           i_cfg_wr_en,
    input  logic [rcr3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcr3_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_outstanding
);

    localparam int PIX_W     = rcr3_pkg::PIX_W;
    localparam int MAX_WIDTH = rcr3_pkg::MAX_WIDTH;
    localparam int WID_W     = rcr3_pkg::WID_W;
    localparam int ROW_W     = rcr3_pkg::ROW_W;
    localparam int RANK_W    = rcr3_pkg::RANK_W;
    localparam int OX_W      = rcr3_pkg::OX_W;
    localparam int OY_W      = rcr3_pkg::OY_W;
    localparam int OV_W      = rcr3_pkg::OV_W;
    localparam int OX_LSB    = rcr3_pkg::OX_LSB;
    localparam int OY_LSB    = rcr3_pkg::OY_LSB;
    localparam int OV_LSB    = rcr3_pkg::OV_LSB;

    typedef struct packed {
        logic [OX_W-1:0] x;
        logic [OY_W-1:0] y;
        logic [OV_W-1:0] v;
        logic            last;
    } t_repaired;

    t_repaired repaired_q[$];

    bit [PIX_W-1:0]  src_rows [2*MAX_WIDTH];
    bit [PIX_W-1:0]  lvl_row [MAX_WIDTH];
    bit [PIX_W-1:0]  win [9];
    bit [PIX_W-1:0]  lvl_delay;
    int unsigned     col_pos;
    int unsigned     row_pos;
    logic [WID_W-1:0]  width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [RANK_W-1:0] rank_reg;
    int              fails = 0;

    // clamp the leveled centre between the rank-th neighbour from each end, each widened to the centre
    function automatic bit [PIX_W-1:0] clamp_by_rank(input bit [PIX_W-1:0] lvl,
                                                     input int unsigned n);
        bit [PIX_W-1:0] nb [8];
        bit [PIX_W-1:0] t;
        bit [PIX_W-1:0] ctr;
        bit [PIX_W-1:0] lo;
        bit [PIX_W-1:0] hi;
        int k;
        int j;
        k = 0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                nb[k] = win[i];
                k++;
            end
        end
        for (int i = 1; i < 8; i++) begin
            t = nb[i];
            j = i;
            while (j > 0 && nb[j-1] > t) begin
                nb[j] = nb[j-1];
                j--;
            end
            nb[j] = t;
        end
        ctr = win[4];
        lo = (nb[n-1] < ctr) ? nb[n-1] : ctr;
        hi = (nb[8-n] > ctr) ? nb[8-n] : ctr;
        if (lvl < lo) return lo;
        if (lvl > hi) return hi;
        return lvl;
    endfunction

    task automatic queue_repaired(input int unsigned x, input int unsigned y,
                                  input bit [PIX_W-1:0] v, input bit last);
        t_repaired r;
        r.x    = x[OX_W-1:0];
        r.y    = y[OY_W-1:0];
        r.v    = v;
        r.last = last;
        repaired_q = {repaired_q, r};
    endtask

    task automatic take_pixel_pair(input bit [PIX_W-1:0] sp, input bit [PIX_W-1:0] lp);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned ci;
        int unsigned slot_new;
        int unsigned slot_old;
        int unsigned cx;
        int unsigned cy;
        bit [PIX_W-1:0] above1;
        bit [PIX_W-1:0] above2;
        bit [PIX_W-1:0] lvl_ctr;
        bit [PIX_W-1:0] v;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < 3) h = 3;
        n = rank_reg;
        if (n < 1) n = 1;
        if (n > 4) n = 4;

        ci       = col_pos % MAX_WIDTH;
        slot_new = (row_pos % 2) * MAX_WIDTH + ci;
        slot_old = ((row_pos + 1) % 2) * MAX_WIDTH + ci;
        above2   = src_rows[slot_new];
        above1   = src_rows[slot_old];
        src_rows[slot_new] = sp;

        lvl_ctr     = lvl_delay;
        lvl_delay   = lvl_row[ci];
        lvl_row[ci] = lp;

        for (int i = 0; i < 8; i++) begin
            if (i % 3 != 2) win[i] = win[i+1];
        end
        win[2] = above2;
        win[5] = above1;
        win[8] = sp;

        if (col_pos >= 1 && row_pos >= 1) begin
            cx = col_pos - 1;
            cy = row_pos - 1;
            if (cx == 0 || cx >= w - 1 || cy == 0 || cy >= h - 1)
                v = win[4];
            else
                v = clamp_by_rank(lvl_ctr, n);
            queue_repaired(cx, cy, v, 1'b0);
        end
        // right column of the row above is complete once its last pixel is in
        if (col_pos == w - 1 && row_pos >= 1)
            queue_repaired(col_pos, row_pos - 1, win[5], 1'b0);
        // last row leaves straight away
        if (row_pos == h - 1)
            queue_repaired(col_pos, row_pos, sp, col_pos == w - 1);

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
    endtask

    task automatic check_repaired;
        t_repaired want;
        t_repaired got;
        got.x    = i_out_data[OX_LSB +: OX_W];
        got.y    = i_out_data[OY_LSB +: OY_W];
        got.v    = i_out_data[OV_LSB +: OV_W];
        got.last = i_out_last;
        if (repaired_q.size() == 0) begin
            $error("unexpected result: out_x %0d out_y %0d value %0h", got.x, got.y, got.v);
            fails++;
        end else begin
            want = repaired_q.pop_front();
            if (got.x !== want.x) begin
                $error("out_x: expected %0d, got %0d", want.x, got.x);
                fails++;
            end
            if (got.y !== want.y) begin
                $error("out_y: expected %0d, got %0d", want.y, got.y);
                fails++;
            end
            if (got.v !== want.v) begin
                $error("value: expected %0h, got %0h (at %0d,%0d)",
                       want.v, got.v, want.x, want.y);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("frame_end: expected %0b, got %0b", want.last, got.last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = rcr3_pkg::WIDTH_RESET;
            height_reg = rcr3_pkg::HEIGHT_RESET;
            rank_reg   = rcr3_pkg::RANK_RESET;
            for (int i = 0; i < 9; i++) win[i] = '0;
            lvl_delay = '0;
            col_pos   = 0;
            row_pos   = 0;
            repaired_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    rcr3_pkg::REG_WIDTH:  width_reg  = i_cfg_data[WID_W-1:0];
                    rcr3_pkg::REG_HEIGHT: height_reg = i_cfg_data[ROW_W-1:0];
                    rcr3_pkg::REG_RANK:   rank_reg   = i_cfg_data[RANK_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                take_pixel_pair(i_in_data[PIX_W-1:0], i_in_data[2*PIX_W-1:PIX_W]);
            if (i_out_valid && i_out_ready)
                check_repaired();
        end
        o_outstanding <= repaired_q.size();
        o_fail_count  <= fails;
    end

endmodule

FILE: sim/rank_clamp_repair_3x3_test.sv
`timescale 1ns / 1ps

module rank_clamp_repair_3x3_test;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rcr3_pkg::IN_W-1:0]       s_axis_tdata  = '0;  // src_pixel, level_pixel
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [rcr3_pkg::OUT_W-1:0]      m_axis_tdata;        // out_x, out_y, value, zeros
    logic                            m_axis_tlast;        // frame_end
    logic                            i_cfg_wr_en   = 1'b0;
    logic [rcr3_pkg::CFG_IDX_W-1:0]  i_cfg_index   = rcr3_pkg::REG_WIDTH;
    logic [rcr3_pkg::CFG_W-1:0]      i_cfg_data    = '0;

    int chk_fails;
    int chk_outstanding;

    bit src_gaps  = 1'b0;
    bit sink_gaps = 1'b0;
    int sink_hold = 0;
    int rand_items = 0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    rank_clamp_repair_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    rank_clamp_repair_3x3_checker repair_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (chk_fails),
        .o_outstanding (chk_outstanding)
    );

    // output back-pressure in random bursts while sink_gaps is set
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            sink_hold     <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_pair(input logic [rcr3_pkg::PIX_W-1:0] sp,
                             input logic [rcr3_pkg::PIX_W-1:0] lp);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lp, sp};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input rcr3_pkg::t_cfg_reg idx,
                             input logic [rcr3_pkg::CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // only once the block has drained; row-0 pixels yield nothing, so allow for latency
    task automatic set_frame(input logic [rcr3_pkg::CFG_W-1:0] wd,
                             input logic [rcr3_pkg::CFG_W-1:0] hd,
                             input logic [rcr3_pkg::CFG_W-1:0] rd);
        @(posedge i_clk);
        while (chk_outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        write_reg(rcr3_pkg::REG_WIDTH, wd);
        write_reg(rcr3_pkg::REG_HEIGHT, hd);
        write_reg(rcr3_pkg::REG_RANK, rd);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [rcr3_pkg::PIX_W-1:0] pick_pixel(
        input int style, input logic [rcr3_pkg::PIX_W-1:0] base);
        case (style)
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'(base + $urandom_range(0, 511) - 256);
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'(base + $urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [rcr3_pkg::PIX_W-1:0] pick_level(
        input logic [rcr3_pkg::PIX_W-1:0] sp);
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 65535));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2:       return sp;
            default: return 16'(sp + $urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    task automatic send_frames(input int nframes, input int w, input int h);
        int style;
        logic [rcr3_pkg::PIX_W-1:0] base;
        logic [rcr3_pkg::PIX_W-1:0] sp;
        for (int f = 0; f < nframes; f++) begin
            style = $urandom_range(0, 3);
            base  = 16'($urandom_range(0, 65535));
            for (int i = 0; i < w * h; i++) begin
                sp = pick_pixel(style, base);
                send_pair(sp, pick_level(sp));
                rand_items++;
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic random_phase;
        logic [rcr3_pkg::CFG_W-1:0] wd;
        logic [rcr3_pkg::CFG_W-1:0] hd;
        logic [rcr3_pkg::CFG_W-1:0] rd;
        int w;
        int h;
        wd = {4'($urandom_range(0, 15)), 12'($urandom_range(0, 14))};
        hd = 16'($urandom_range(0, 7));
        rd = {13'($urandom_range(0, 8191)), 3'($urandom_range(0, 7))};
        w  = (wd[rcr3_pkg::WID_W-1:0] < 12'd3) ? 3 : int'(wd[rcr3_pkg::WID_W-1:0]);
        h  = (hd < 16'd3) ? 3 : int'(hd);
        set_frame(wd, hd, rd);
        send_frames($urandom_range(1, 2), w, h);
    endtask

    initial begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int guard;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // below-minimum registers saturate to a 3x3 frame, rank 1
        set_frame(16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 9; i++)
            send_pair((i % 2) ? 16'hFFFF : 16'h0000, (i % 2) ? 16'h0000 : 16'hFFFF);
        s_axis_tvalid <= 1'b0;

        // rank above range saturates to 4; level below, above and inside the bounds
        set_frame(16'd5, 16'd4, 16'd7);
        for (int i = 0; i < 20; i++)
            send_pair(16'(i * 3449), (i % 3 == 0) ? 16'h0000 :
                                     (i % 3 == 1) ? 16'hFFFF : 16'(i * 3449 + 1));
        s_axis_tvalid <= 1'b0;

        src_gaps  = 1'b1;
        sink_gaps = 1'b1;

        // tallest frame, cut short by lowering the height between rows
        set_frame(16'd3, 16'hFFFF, 16'd2);
        for (int i = 0; i < 12; i++)
            send_pair(pick_pixel(0, 16'h0), pick_level(16'($urandom_range(0, 65535))));
        s_axis_tvalid <= 1'b0;
        set_frame(16'd3, 16'd5, 16'd3);
        for (int i = 0; i < 3; i++)
            send_pair(pick_pixel(0, 16'h0), pick_level(16'($urandom_range(0, 65535))));
        s_axis_tvalid <= 1'b0;

        // width register at its top value: a long first row, then narrowed mid-row
        set_frame(16'hFFFF, 16'd3, 16'd4);
        for (int i = 0; i < 24; i++)
            send_pair(pick_pixel(0, 16'h0), pick_level(16'($urandom_range(0, 65535))));
        s_axis_tvalid <= 1'b0;
        set_frame(16'd3, 16'd3, 16'd4);
        for (int i = 0; i < 7; i++)
            send_pair(pick_pixel(0, 16'h0), pick_level(16'($urandom_range(0, 65535))));
        s_axis_tvalid <= 1'b0;

        rand_items = 0;
        while (rand_items < 90) begin
            src_gaps  = $urandom_range(0, 1);
            sink_gaps = $urandom_range(0, 1);
            random_phase();
        end
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        while (rand_items < 140)
            random_phase();

        guard = 0;
        while (chk_outstanding != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
        if (chk_outstanding != 0)
            $error("%0d expected results never arrived", chk_outstanding);
        if (chk_fails == 0 && chk_outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
